// ===== rtl/mfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mfc_pkg;

    localparam int unsigned LIM_W      = 31;
    localparam int unsigned NUM_W      = 48;
    localparam int unsigned DEN_W      = 32;
    localparam int unsigned DIV_STAGES = 16;
    localparam int unsigned DEQ_STAGES = 3;
    localparam int unsigned POS_BITS   = 16;
    localparam int unsigned VAL_BITS   = 12;

    localparam logic [DEN_W-1:0] KP_MAX_Q = 32'd32768000;
    localparam logic [DEN_W-1:0] KD_MAX_Q = 32'd327680;
    localparam logic [3:0]       FRAME_DLC = 4'd8;

    // kp span is 125 * 2^18, kd span is 5 * 2^16
    localparam int unsigned KP_SHIFT  = 18;
    localparam int unsigned KP_RSHIFT = 26;
    localparam logic [19:0] KP_RECIP  = 20'd536871;
    localparam int unsigned KD_SHIFT  = 16;
    localparam int unsigned KD_RSHIFT = 18;
    localparam logic [16:0] KD_RECIP  = 17'd52429;

    typedef enum logic [1:0] {
        REG_POS_LIMIT = 2'd0,
        REG_VEL_LIMIT = 2'd1,
        REG_TRQ_LIMIT = 2'd2
    } t_reg_idx;

    typedef enum logic {
        FUNC_PACK  = 1'b0,
        FUNC_PARSE = 1'b1
    } t_func;

    typedef struct packed {
        logic               func;
        logic [7:0]         motor_id;
        logic signed [31:0] cmd_position;
        logic signed [31:0] cmd_velocity;
        logic signed [31:0] cmd_kp;
        logic signed [31:0] cmd_kd;
        logic signed [31:0] cmd_torque;
        logic [10:0]        rx_id;
        logic [3:0]         rx_dlc;
        logic [63:0]        rx_data;
        logic [10:0]        exp_rx_id;
    } t_in;

    typedef struct packed {
        logic               ok;
        logic [10:0]        tx_id;
        logic [3:0]         tx_dlc;
        logic [63:0]        tx_data;
        logic [3:0]         fb_slave_id;
        logic [3:0]         fb_state;
        logic signed [31:0] fb_position;
        logic signed [31:0] fb_velocity;
        logic signed [31:0] fb_torque;
        logic signed [7:0]  fb_driver_temp;
        logic signed [7:0]  fb_motor_temp;
    } t_out;

    typedef struct packed {
        logic        ok;
        logic        func;
        logic [7:0]  motor_id;
        logic [3:0]  fb_slave_id;
        logic [3:0]  fb_state;
        logic [7:0]  driver_temp;
        logic [7:0]  motor_temp;
    } t_side;

    typedef struct packed {
        t_side             side;
        logic [NUM_W-1:0]  num_p;
        logic [NUM_W-1:0]  num_v;
        logic [NUM_W-1:0]  num_kp;
        logic [NUM_W-1:0]  num_kd;
        logic [NUM_W-1:0]  num_t;
        logic [DEN_W-1:0]  den_p;
        logic [DEN_W-1:0]  den_v;
        logic [DEN_W-1:0]  den_t;
        logic [NUM_W-1:0]  prod_p;
        logic [NUM_W-1:0]  prod_v;
        logic [NUM_W-1:0]  prod_t;
    } t_s1;

endpackage
`default_nettype wire

// ===== rtl/mfc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mfc_front
    import mfc_pkg::*;
(
    input  wire t_in              i_data,
    input  wire logic [LIM_W-1:0] i_pos_limit,
    input  wire logic [LIM_W-1:0] i_vel_limit,
    input  wire logic [LIM_W-1:0] i_trq_limit,
    output t_s1                   o_s1
);

    logic               limits_ok;
    logic signed [32:0] ps, vs, ts, lps, lvs, lts;
    logic [32:0]        off_p, off_v, off_t;
    logic               rng_p, rng_v, rng_t, rng_kp, rng_kd;
    logic               pack_ok, parse_ok;
    logic [7:0]         b0;
    logic [15:0]        raw_p;
    logic [11:0]        raw_v, raw_t;
    logic [NUM_W-1:0]   ekp, ekd;

    always_comb begin
        limits_ok = (i_pos_limit != '0) && (i_vel_limit != '0) && (i_trq_limit != '0);
        ps  = 33'(i_data.cmd_position);
        vs  = 33'(i_data.cmd_velocity);
        ts  = 33'(i_data.cmd_torque);
        lps = signed'({2'b00, i_pos_limit});
        lvs = signed'({2'b00, i_vel_limit});
        lts = signed'({2'b00, i_trq_limit});
        rng_p  = (ps >= -lps) && (ps <= lps);
        rng_v  = (vs >= -lvs) && (vs <= lvs);
        rng_t  = (ts >= -lts) && (ts <= lts);
        rng_kp = !i_data.cmd_kp[31] && (unsigned'(i_data.cmd_kp) <= KP_MAX_Q);
        rng_kd = !i_data.cmd_kd[31] && (unsigned'(i_data.cmd_kd) <= KD_MAX_Q);
        off_p = unsigned'(ps + lps);
        off_v = unsigned'(vs + lvs);
        off_t = unsigned'(ts + lts);
        ekp   = NUM_W'(unsigned'(i_data.cmd_kp));
        ekd   = NUM_W'(unsigned'(i_data.cmd_kd));

        pack_ok = (i_data.motor_id != '0) && limits_ok && rng_p && rng_v && rng_t
                  && rng_kp && rng_kd;

        b0    = i_data.rx_data[63:56];
        raw_p = i_data.rx_data[55:40];
        raw_v = i_data.rx_data[39:28];
        raw_t = i_data.rx_data[27:16];
        parse_ok = limits_ok && (i_data.rx_id == i_data.exp_rx_id)
                   && (i_data.rx_dlc == FRAME_DLC) && (b0[3:0] == i_data.motor_id[3:0]);

        o_s1.side.ok          = (i_data.func == FUNC_PACK) ? pack_ok : parse_ok;
        o_s1.side.func        = i_data.func;
        o_s1.side.motor_id    = i_data.motor_id;
        o_s1.side.fb_slave_id = b0[3:0];
        o_s1.side.fb_state    = b0[7:4];
        o_s1.side.driver_temp = i_data.rx_data[15:8];
        o_s1.side.motor_temp  = i_data.rx_data[7:0];

        o_s1.num_p  = (NUM_W'(off_p) << POS_BITS) - NUM_W'(off_p);
        o_s1.num_v  = (NUM_W'(off_v) << VAL_BITS) - NUM_W'(off_v);
        o_s1.num_t  = (NUM_W'(off_t) << VAL_BITS) - NUM_W'(off_t);
        o_s1.num_kp = (ekp << VAL_BITS) - ekp;
        o_s1.num_kd = (ekd << VAL_BITS) - ekd;
        o_s1.den_p  = {i_pos_limit, 1'b0};
        o_s1.den_v  = {i_vel_limit, 1'b0};
        o_s1.den_t  = {i_trq_limit, 1'b0};
        o_s1.prod_p = NUM_W'(raw_p * {i_pos_limit, 1'b0});
        o_s1.prod_v = NUM_W'(raw_v * {i_vel_limit, 1'b0});
        o_s1.prod_t = NUM_W'(raw_t * {i_trq_limit, 1'b0});
    end

endmodule
`default_nettype wire

// ===== rtl/mfc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mfc_div
    import mfc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [NUM_W-1:0]      i_num,
    input  wire logic [DEN_W-1:0]      i_den,
    output logic [DIV_STAGES-1:0]      o_q
);

    logic [NUM_W-1:0]      r_rem [DIV_STAGES];
    logic [DEN_W-1:0]      r_den [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_q   [DIV_STAGES];
    logic [NUM_W-1:0]      n_rem [DIV_STAGES];
    logic [DIV_STAGES-1:0] n_q   [DIV_STAGES];

    always_comb begin
        logic [NUM_W-1:0]      rem_in;
        logic [DEN_W-1:0]      den_in;
        logic [DIV_STAGES-1:0] q_in;
        logic [NUM_W-1:0]      trial;
        for (int i = 0; i < DIV_STAGES; i++) begin
            rem_in = (i == 0) ? i_num : r_rem[(i == 0) ? 0 : i - 1];
            den_in = (i == 0) ? i_den : r_den[(i == 0) ? 0 : i - 1];
            q_in   = (i == 0) ? '0    : r_q[(i == 0) ? 0 : i - 1];
            trial  = NUM_W'(den_in) << (DIV_STAGES - 1 - i);
            n_q[i] = q_in;
            if (rem_in >= trial) begin
                n_rem[i] = rem_in - trial;
                n_q[i][DIV_STAGES-1-i] = 1'b1;
            end else begin
                n_rem[i] = rem_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                r_rem[i] <= n_rem[i];
                r_q[i]   <= n_q[i];
                r_den[i] <= (i == 0) ? i_den : r_den[(i == 0) ? 0 : i - 1];
            end
        end
    end

    assign o_q = r_q[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/mfc_deq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mfc_deq
    import mfc_pkg::*;
#(
    parameter int unsigned BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_x,
    input  wire logic [LIM_W-1:0] i_lim,
    output logic [31:0]           o_val
);

    localparam int unsigned SW = NUM_W - BITS + 1;
    localparam logic [SW-1:0] MAXC = SW'((64'd1 << BITS) - 64'd1);

    logic [SW-1:0] r_s1, r_s2, n_s1, n_s2, s2a;
    logic [32:0]   r_q1, r_q2, n_q1, n_q2, q3;
    logic [SW-1:0] s4;
    logic [31:0]   r_val;

    always_comb begin
        n_s1 = SW'(i_x >> BITS) + SW'(i_x & NUM_W'(MAXC));
        n_q1 = 33'(i_x >> BITS);
        s2a  = (r_s1 >> BITS) + (r_s1 & MAXC);
        n_s2 = (s2a >> BITS) + (s2a & MAXC);
        n_q2 = r_q1 + 33'(r_s1 >> BITS) + 33'(s2a >> BITS);
        s4   = (r_s2 >> BITS) + (r_s2 & MAXC);
        q3   = r_q2 + 33'(r_s2 >> BITS) + 33'(s4 >= MAXC);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1  <= n_s1;
            r_q1  <= n_q1;
            r_s2  <= n_s2;
            r_q2  <= n_q2;
            r_val <= q3[31:0] - {1'b0, i_lim};
        end
    end

    assign o_val = r_val;

endmodule
`default_nettype wire

// ===== rtl/mit_motor_frame_codec_core.sv =====
// MIT-mode motor frame codec.
// Input channel i_valid/o_stall carries one t_in item per transfer; func selects
// packing a motor command into an 8-byte CAN payload or parsing a feedback frame.
// Output channel o_valid/i_stall carries one t_out result per item, in order;
// failed checks give an all-zero result with ok low.
// The user writes limits over the APB port (0x0 position, 0x4 velocity, 0x8 torque)
// only while no item is in flight (not enforced by the block); pready is always high.
// From input transfer to output valid an item passes one check stage,
// a 16-stage restoring divider (one quotient bit per stage) and the output
// register. The gain codes come from a reciprocal multiply after the check stage
// and the dequantizer runs three stages; both run alongside and are delayed to match.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_stall rises in the same cycle; nothing is dropped or repeated.
// Synchronous reset clears the limits to zero and all valid bits; with zero
// limits every item returns ok low.
`timescale 1ns / 1ps
`default_nettype none
module mit_motor_frame_codec_core
    import mfc_pkg::*;
#(
    parameter int unsigned MIT_MODE_CODE = 0
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in         i_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out             o_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned SIDE_D = DIV_STAGES;
    localparam int unsigned DEQ_D  = DIV_STAGES - DEQ_STAGES;

    logic [LIM_W-1:0] r_plim, r_vlim, r_tlim;
    logic             en;
    t_s1              s1_comb, r_s1;
    logic             r_vld [SIDE_D+1];
    t_side            r_side [SIDE_D];
    logic [31:0]      r_dp [DEQ_D];
    logic [31:0]      r_dv [DEQ_D];
    logic [31:0]      r_dt [DEQ_D];
    logic [DIV_STAGES-1:0] q_p, q_v, q_t;
    logic [31:0]      dq_p, dq_v, dq_t;
    logic [18:0]      kp_m;
    logic [14:0]      kd_m;
    logic [38:0]      kp_prod;
    logic [31:0]      kd_prod;
    logic [2*VAL_BITS-1:0] gain_q;
    logic [2*VAL_BITS-1:0] r_kq [SIDE_D];
    logic             r_ov;
    t_out             r_out, n_out;
    t_side            side_f;
    t_reg_idx         ridx;

    assign pready = 1'b1;
    assign ridx   = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plim <= '0;
            r_vlim <= '0;
            r_tlim <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (ridx)
                REG_POS_LIMIT: r_plim <= pwdata[LIM_W-1:0];
                REG_VEL_LIMIT: r_vlim <= pwdata[LIM_W-1:0];
                REG_TRQ_LIMIT: r_tlim <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            REG_POS_LIMIT: prdata = {1'b0, r_plim};
            REG_VEL_LIMIT: prdata = {1'b0, r_vlim};
            REG_TRQ_LIMIT: prdata = {1'b0, r_tlim};
            default:       prdata = '0;
        endcase
    end

    assign en      = !(r_ov && i_stall);
    assign o_stall = !en;

    mfc_front u_front (
        .i_data      (i_data),
        .i_pos_limit (r_plim),
        .i_vel_limit (r_vlim),
        .i_trq_limit (r_tlim),
        .o_s1        (s1_comb)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= s1_comb;
        end
    end

    mfc_div u_div_p  (.i_clk(i_clk), .i_en(en), .i_num(r_s1.num_p),  .i_den(r_s1.den_p), .o_q(q_p));
    mfc_div u_div_v  (.i_clk(i_clk), .i_en(en), .i_num(r_s1.num_v),  .i_den(r_s1.den_v), .o_q(q_v));
    mfc_div u_div_t  (.i_clk(i_clk), .i_en(en), .i_num(r_s1.num_t),  .i_den(r_s1.den_t), .o_q(q_t));

    always_comb begin
        kp_m    = r_s1.num_kp[KP_SHIFT +: 19];
        kd_m    = r_s1.num_kd[KD_SHIFT +: 15];
        kp_prod = 39'(kp_m) * 39'(KP_RECIP);
        kd_prod = 32'(kd_m) * 32'(KD_RECIP);
        gain_q  = {kp_prod[KP_RSHIFT +: VAL_BITS], kd_prod[KD_RSHIFT +: VAL_BITS]};
    end

    mfc_deq #(.BITS(POS_BITS)) u_deq_p (
        .i_clk(i_clk), .i_en(en), .i_x(r_s1.prod_p), .i_lim(r_plim), .o_val(dq_p)
    );
    mfc_deq #(.BITS(VAL_BITS)) u_deq_v (
        .i_clk(i_clk), .i_en(en), .i_x(r_s1.prod_v), .i_lim(r_vlim), .o_val(dq_v)
    );
    mfc_deq #(.BITS(VAL_BITS)) u_deq_t (
        .i_clk(i_clk), .i_en(en), .i_x(r_s1.prod_t), .i_lim(r_tlim), .o_val(dq_t)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < SIDE_D; i++) begin
                r_side[i] <= (i == 0) ? r_s1.side : r_side[(i == 0) ? 0 : i - 1];
                r_kq[i]   <= (i == 0) ? gain_q : r_kq[(i == 0) ? 0 : i - 1];
            end
            for (int i = 0; i < DEQ_D; i++) begin
                r_dp[i] <= (i == 0) ? dq_p : r_dp[(i == 0) ? 0 : i - 1];
                r_dv[i] <= (i == 0) ? dq_v : r_dv[(i == 0) ? 0 : i - 1];
                r_dt[i] <= (i == 0) ? dq_t : r_dt[(i == 0) ? 0 : i - 1];
            end
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= SIDE_D; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            for (int i = 0; i <= SIDE_D; i++) begin
                r_vld[i] <= (i == 0) ? i_valid : r_vld[(i == 0) ? 0 : i - 1];
            end
            r_ov <= r_vld[SIDE_D];
        end
    end

    always_comb begin
        side_f = r_side[SIDE_D-1];
        n_out  = '0;
        if (side_f.ok) begin
            n_out.ok = 1'b1;
            if (side_f.func == FUNC_PACK) begin
                n_out.tx_id   = {3'(MIT_MODE_CODE), side_f.motor_id};
                n_out.tx_dlc  = FRAME_DLC;
                n_out.tx_data = {q_p[POS_BITS-1:0], q_v[VAL_BITS-1:0],
                                 r_kq[SIDE_D-1][2*VAL_BITS-1:VAL_BITS],
                                 r_kq[SIDE_D-1][VAL_BITS-1:0], q_t[VAL_BITS-1:0]};
            end else begin
                n_out.fb_slave_id    = side_f.fb_slave_id;
                n_out.fb_state       = side_f.fb_state;
                n_out.fb_position    = r_dp[DEQ_D-1];
                n_out.fb_velocity    = r_dv[DEQ_D-1];
                n_out.fb_torque      = r_dt[DEQ_D-1];
                n_out.fb_driver_temp = side_f.driver_temp;
                n_out.fb_motor_temp  = side_f.motor_temp;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.ok) |-> (o_data == '0))
        else $error("failed result carries nonzero fields");

    a_dlc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.tx_dlc != '0) |-> (o_data.tx_dlc == FRAME_DLC && o_data.ok))
        else $error("bad tx_dlc");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted item lost at entry");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_ov && i_stall))
        else $error("stall without a waiting result");

endmodule
`default_nettype wire

// ===== bench/tb_mit_motor_frame_codec_core.sv =====
`timescale 1ns / 1ps
module tb_mit_motor_frame_codec_core;
    import mfc_pkg::*;

    localparam int LATENCY = 18;
    localparam int MODE_CODE = 0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out        o_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mit_motor_frame_codec_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    logic [30:0] lim_pos, lim_vel, lim_trq;
    t_in  pending_frames[$];
    t_out expected_frames[$];
    int   error_count = 0;
    int   gap_left = 0;
    int   stall_left = 0;

    function automatic logic [15:0] quantize(longint v, longint lo, longint span, int bits);
        longint maxc;
        maxc = (longint'(1) << bits) - 1;
        return 16'((v - lo) * maxc / span);
    endfunction

    function automatic logic [31:0] dequantize(longint raw, longint lim, int bits);
        longint maxc;
        maxc = (longint'(1) << bits) - 1;
        return 32'((raw * 2 * lim) / maxc - lim);
    endfunction

    function automatic t_out predict_frame(t_in d);
        t_out r;
        longint lp, lv, lt, pos, vel, kp, kd, tq;
        logic [7:0] b0;
        logic [15:0] qp, qv, qkp, qkd, qt;
        r = '0;
        lp = lim_pos; lv = lim_vel; lt = lim_trq;
        if (lp == 0 || lv == 0 || lt == 0) return r;
        if (d.func == FUNC_PACK) begin
            pos = d.cmd_position; vel = d.cmd_velocity; kp = d.cmd_kp;
            kd = d.cmd_kd; tq = d.cmd_torque;
            if (d.motor_id == 0 || pos < -lp || pos > lp || vel < -lv || vel > lv
                || kp < 0 || kp > KP_MAX_Q || kd < 0 || kd > KD_MAX_Q
                || tq < -lt || tq > lt) return r;
            qp  = quantize(pos, -lp, 2 * lp, 16);
            qv  = quantize(vel, -lv, 2 * lv, 12);
            qkp = quantize(kp, 0, KP_MAX_Q, 12);
            qkd = quantize(kd, 0, KD_MAX_Q, 12);
            qt  = quantize(tq, -lt, 2 * lt, 12);
            r.ok = 1'b1;
            r.tx_id = {3'(MODE_CODE), d.motor_id};
            r.tx_dlc = FRAME_DLC;
            r.tx_data = {qp, qv[11:0], qkp[11:0], qkd[11:0], qt[11:0]};
        end else begin
            b0 = d.rx_data[63:56];
            if (d.rx_id != d.exp_rx_id || d.rx_dlc != FRAME_DLC
                || b0[3:0] != d.motor_id[3:0]) return r;
            r.ok = 1'b1;
            r.fb_slave_id = b0[3:0];
            r.fb_state = b0[7:4];
            r.fb_position = dequantize(d.rx_data[55:40], lp, 16);
            r.fb_velocity = dequantize(d.rx_data[39:28], lv, 12);
            r.fb_torque = dequantize(d.rx_data[27:16], lt, 12);
            r.fb_driver_temp = d.rx_data[15:8];
            r.fb_motor_temp = d.rx_data[7:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic int random_gap();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_frames.push_back(predict_frame(i_data));
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_frames.size() > 0) begin
                    i_data <= pending_frames.pop_front();
                    i_valid <= 1'b1;
                    gap_left <= random_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch("unexpected result", o_data.tx_data, 0);
                end else begin
                    want = expected_frames.pop_front();
                    if (o_data.ok !== want.ok) report_mismatch("ok", o_data.ok, want.ok);
                    if (o_data.tx_id !== want.tx_id)
                        report_mismatch("tx_id", o_data.tx_id, want.tx_id);
                    if (o_data.tx_dlc !== want.tx_dlc)
                        report_mismatch("tx_dlc", o_data.tx_dlc, want.tx_dlc);
                    if (o_data.tx_data !== want.tx_data)
                        report_mismatch("tx_data", o_data.tx_data, want.tx_data);
                    if (o_data.fb_slave_id !== want.fb_slave_id)
                        report_mismatch("fb_slave_id", o_data.fb_slave_id, want.fb_slave_id);
                    if (o_data.fb_state !== want.fb_state)
                        report_mismatch("fb_state", o_data.fb_state, want.fb_state);
                    if (o_data.fb_position !== want.fb_position)
                        report_mismatch("fb_position", o_data.fb_position, want.fb_position);
                    if (o_data.fb_velocity !== want.fb_velocity)
                        report_mismatch("fb_velocity", o_data.fb_velocity, want.fb_velocity);
                    if (o_data.fb_torque !== want.fb_torque)
                        report_mismatch("fb_torque", o_data.fb_torque, want.fb_torque);
                    if (o_data.fb_driver_temp !== want.fb_driver_temp)
                        report_mismatch("fb_driver_temp", o_data.fb_driver_temp,
                                        want.fb_driver_temp);
                    if (o_data.fb_motor_temp !== want.fb_motor_temp)
                        report_mismatch("fb_motor_temp", o_data.fb_motor_temp,
                                        want.fb_motor_temp);
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall <= 1'b1;
            end else begin
                stall_left <= random_gap();
                i_stall <= 1'b0;
            end
        end
    end

    task automatic write_limit(t_reg_idx idx, logic [30:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 4'(idx) << 2; pwdata <= {1'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_POS_LIMIT: lim_pos = value;
            REG_VEL_LIMIT: lim_vel = value;
            default:       lim_trq = value;
        endcase
    endtask

    task automatic drain();
        while (pending_frames.size() > 0 || i_valid || expected_frames.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] in_limit(logic [30:0] lim);
        longint l;
        int mode;
        l = lim;
        mode = $urandom_range(0, 9);
        if (mode == 0) return 32'(-l);
        if (mode == 1) return 32'(l);
        if (mode == 2) return 32'(l + 1);
        if (mode == 3) return $urandom;
        return 32'(longint'($urandom) % (l + 1) * (($urandom_range(0, 1) != 0) ? 1 : -1));
    endfunction

    function automatic logic signed [31:0] gain(logic [31:0] top);
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0) return 0;
        if (mode == 1) return top;
        if (mode == 2) return top + 1;
        if (mode == 3) return $urandom;
        return $urandom_range(0, top);
    endfunction

    function automatic t_in random_frame();
        t_in d;
        d = '0;
        d.func = 1'($urandom_range(0, 1));
        d.motor_id = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom);
        if (d.func == FUNC_PACK) begin
            d.cmd_position = in_limit(lim_pos);
            d.cmd_velocity = in_limit(lim_vel);
            d.cmd_kp = gain(KP_MAX_Q);
            d.cmd_kd = gain(KD_MAX_Q);
            d.cmd_torque = in_limit(lim_trq);
        end
        d.rx_data = {$urandom, $urandom};
        d.exp_rx_id = 11'($urandom);
        d.rx_id = ($urandom_range(0, 7) == 0) ? 11'($urandom) : d.exp_rx_id;
        d.rx_dlc = ($urandom_range(0, 7) == 0) ? 4'($urandom) : FRAME_DLC;
        if ($urandom_range(0, 7) != 0) d.rx_data[59:56] = d.motor_id[3:0];
        if (d.func == FUNC_PARSE && $urandom_range(0, 3) == 0) begin
            d.cmd_position = $urandom; d.cmd_velocity = $urandom;
            d.cmd_kp = $urandom; d.cmd_kd = $urandom; d.cmd_torque = $urandom;
        end
        return d;
    endfunction

    initial begin
        t_in d;
        lim_pos = '0; lim_vel = '0; lim_trq = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < 3; k++) pending_frames.push_back(random_frame());
        drain();
        write_limit(REG_POS_LIMIT, 31'h7FFF_FFFF);
        write_limit(REG_VEL_LIMIT, 31'h7FFF_FFFF);
        write_limit(REG_TRQ_LIMIT, 31'h7FFF_FFFF);
        d = '0;
        d.func = FUNC_PACK; d.motor_id = 8'hFF;
        d.cmd_position = 32'sh8000_0001; d.cmd_velocity = 32'sh7FFF_FFFF;
        d.cmd_kp = KP_MAX_Q; d.cmd_kd = KD_MAX_Q; d.cmd_torque = 32'sh8000_0001;
        pending_frames.push_back(d);
        d.cmd_position = 32'sh8000_0000;
        pending_frames.push_back(d);
        d.cmd_position = 0; d.cmd_kp = -1;
        pending_frames.push_back(d);
        d.cmd_kp = 0; d.cmd_kd = KD_MAX_Q + 1;
        pending_frames.push_back(d);
        d.cmd_kd = 0; d.motor_id = 0;
        pending_frames.push_back(d);
        d = '0;
        d.func = FUNC_PARSE; d.motor_id = 8'hA5; d.rx_dlc = FRAME_DLC;
        d.rx_id = 11'h7FF; d.exp_rx_id = 11'h7FF;
        d.rx_data = 64'hF5FF_FFFF_FFFF_FFFF;
        pending_frames.push_back(d);
        d.rx_data = 64'h0500_0000_0000_0000;
        pending_frames.push_back(d);
        d.rx_dlc = 4'd15;
        pending_frames.push_back(d);
        d.rx_dlc = FRAME_DLC; d.rx_id = 11'h0;
        pending_frames.push_back(d);
        d.rx_id = 11'h7FF; d.motor_id = 8'h04;
        pending_frames.push_back(d);
        drain();
        write_limit(REG_POS_LIMIT, 31'd1);
        write_limit(REG_VEL_LIMIT, 31'd1);
        write_limit(REG_TRQ_LIMIT, 31'd1);
        for (int k = 0; k < 10; k++) pending_frames.push_back(random_frame());
        drain();
        for (int phase = 0; phase < 7; phase++) begin
            write_limit(REG_POS_LIMIT, (phase == 3) ? 31'd0 : 31'($urandom_range(1, 32'h7FFF_FFFF)
                        >> $urandom_range(0, 24)));
            write_limit(REG_VEL_LIMIT, 31'($urandom) >> $urandom_range(0, 20) | 31'd1);
            write_limit(REG_TRQ_LIMIT, (phase == 5) ? 31'h7FFF_FFFF : 31'($urandom) | 31'd1);
            for (int k = 0; k < 200; k++) pending_frames.push_back(random_frame());
            drain();
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mfc_pkg.sv
rtl/mfc_front.sv
rtl/mfc_div.sv
rtl/mfc_deq.sv
rtl/mit_motor_frame_codec_core.sv
bench/tb_mit_motor_frame_codec_core.sv
